// ----- rtl/sbh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_pkg
// Types, constants and round functions shared by the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sbh_pkg;

	localparam logic [7:0] PAD_MARK_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS         = 6'd56;
	localparam logic [5:0] LAST_POS        = 6'h3f;
	localparam logic [5:0] LAST_ROUND      = 6'd63;
	localparam logic [2:0] LAST_WORD_INDEX = 3'd7;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_COMPRESS,
		ST_FINISH,
		ST_OUTPUT
	} sbh_state_t;

	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_MARK,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic       shift_byte;
		byte_sel_t  byte_sel;
		logic       count_byte;
		logic       load_vars;
		logic       round_en;
		logic [5:0] round;
		logic       add_hash;
		logic       restart;
		logic [2:0] word_index;
	} sbh_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} sbh_sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- rtl/sbh_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_in_if
// Message byte channel: one optional byte and an end-of-message flag.
// ----------------------------------------------------------------------------
interface sbh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       message_end;

	modport source(output valid, data_byte, byte_present, message_end, input ready);
	modport sink(input valid, data_byte, byte_present, message_end, output ready);
endinterface

// ----- rtl/sbh_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_out_if
// Digest channel: one 32-bit digest word per transaction.
// ----------------------------------------------------------------------------
interface sbh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/sbh_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_controller
// Sequencer: byte gathering, padding, round counting and digest readout.
// ----------------------------------------------------------------------------
module sbh_controller
	import sbh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_byte_present,
	input  logic     in_message_end,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  sbh_sts_t sts,
	output sbh_cmd_t cmd
);

	sbh_state_t state_q, state_d;
	sbh_state_t ret_q, ret_d;
	logic [5:0] round_q;
	logic [2:0] widx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			round_q <= '0;
			widx_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == ST_COMPRESS) begin
				round_q <= round_q + 6'd1;
			end else begin
				round_q <= '0;
			end
			if (state_q == ST_OUTPUT && out_ready) begin
				widx_q <= widx_q + 3'd1;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		ret_d          = ret_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd            = '0;
		cmd.byte_sel   = BSEL_DATA;
		cmd.round      = round_q;
		cmd.word_index = widx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_byte_present) begin
						cmd.shift_byte = 1'b1;
						cmd.count_byte = 1'b1;
					end
					if (in_byte_present && sts.pos == LAST_POS) begin
						cmd.load_vars = 1'b1;
						state_d       = ST_COMPRESS;
						ret_d         = in_message_end ? ST_PAD_MARK : ST_IDLE;
					end else if (in_message_end) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_sel   = BSEL_MARK;
				if (sts.pos == LAST_POS) begin
					cmd.load_vars = 1'b1;
					state_d       = ST_COMPRESS;
					ret_d         = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				// a block that cannot hold the length fills to its end first
				if (sts.pos == LEN_POS) begin
					state_d = ST_PAD_LEN;
				end else begin
					cmd.shift_byte = 1'b1;
					cmd.byte_sel   = BSEL_ZERO;
					if (sts.pos == LAST_POS) begin
						cmd.load_vars = 1'b1;
						state_d       = ST_COMPRESS;
						ret_d         = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_LEN: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_sel   = BSEL_LEN;
				if (sts.pos == LAST_POS) begin
					cmd.load_vars = 1'b1;
					state_d       = ST_COMPRESS;
					ret_d         = ST_OUTPUT;
				end
			end
			ST_COMPRESS: begin
				cmd.round_en = 1'b1;
				if (round_q == LAST_ROUND) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.add_hash = 1'b1;
				state_d      = ret_q;
			end
			ST_OUTPUT: begin
				out_valid = 1'b1;
				if (out_ready && widx_q == LAST_WORD_INDEX) begin
					cmd.restart = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/sbh_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_datapath
// Block window, length counter, working variables, round logic and hash.
// ----------------------------------------------------------------------------
module sbh_datapath
	import sbh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sbh_cmd_t    cmd,
	input  logic [7:0]  data_byte,
	output sbh_sts_t    sts,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// block window: the oldest word sits in the top 32 bits
	logic [511:0]      win_q;
	logic [5:0]        pos_q;
	logic [60:0]       count_q;
	logic [31:0]       hash_q [8];
	logic [31:0]       var_q [8];

	logic [7:0][7:0]   len_bytes;
	logic [7:0]        byte_mux;
	logic [31:0]       w0, w1, w9, w14, w_new;
	logic [31:0]       t1, t2;
	logic [31:0]       ch, maj;

	assign len_bytes = {count_q, 3'b000};

	always_comb begin
		case (cmd.byte_sel)
			BSEL_DATA: byte_mux = data_byte;
			BSEL_MARK: byte_mux = PAD_MARK_BYTE;
			BSEL_ZERO: byte_mux = 8'h00;
			BSEL_LEN:  byte_mux = len_bytes[3'd7 - pos_q[2:0]];
			default:   byte_mux = 8'h00;
		endcase
	end

	assign w0    = win_q[511:480];
	assign w1    = win_q[479:448];
	assign w9    = win_q[223:192];
	assign w14   = win_q[63:32];
	assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

	assign ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1  = var_q[7] + big_sigma1(var_q[4]) + ch + ROUND_K[cmd.round] + w0;
	assign t2  = big_sigma0(var_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			win_q <= {win_q[503:0], byte_mux};
		end else if (cmd.round_en) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.load_vars) begin
			var_q <= hash_q;
		end else if (cmd.round_en) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			hash_q  <= HASH_IV;
		end else begin
			if (cmd.shift_byte) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.restart) begin
				count_q <= '0;
				hash_q  <= HASH_IV;
			end else begin
				if (cmd.count_byte) begin
					count_q <= count_q + 61'd1;
				end
				if (cmd.add_hash) begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + var_q[i];
					end
				end
			end
		end
	end

	assign sts.pos     = pos_q;
	assign digest_word = hash_q[cmd.word_index];
	assign word_index  = cmd.word_index;
	assign last_word   = (cmd.word_index == LAST_WORD_INDEX);

endmodule

// ----- rtl/sha256_byte_stream_hasher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream, one byte per transaction, digest as 8 words.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle, while the input is not stalled, into
// a 64-byte block window. The transaction that fills a block stalls the input
// while the single round unit runs the 64 rounds, one per cycle, and then
// folds the working variables into the hash. A transaction with message_end
// set starts padding, which shifts the pad and length bytes through the same
// window, with one or two compressions along the way; the input stays stalled
// until the eight digest words, word 0 first, have been taken on the output.
// Hash state and length then return to their initial values and the next
// byte begins a new message.
module sha256_byte_stream_hasher_unit
	import sbh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	sbh_in_if.sink   byte_in,
	sbh_out_if.source digest_out
);

	sbh_cmd_t cmd;
	sbh_sts_t sts;

	sbh_controller u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (byte_in.valid),
		.in_byte_present (byte_in.byte_present),
		.in_message_end  (byte_in.message_end),
		.in_ready        (byte_in.ready),
		.out_valid       (digest_out.valid),
		.out_ready       (digest_out.ready),
		.sts             (sts),
		.cmd             (cmd)
	);

	sbh_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (byte_in.data_byte),
		.sts         (sts),
		.digest_word (digest_out.digest_word),
		.word_index  (digest_out.word_index),
		.last_word   (digest_out.last_word)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in.ready |-> !digest_out.valid)
		else $error("input taken while digest pending");

	a_restart_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		digest_out.valid && digest_out.ready && digest_out.last_word |=> byte_in.ready)
		else $error("no restart after final digest word");

	a_full_block_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in.valid && byte_in.ready && byte_in.byte_present && sts.pos == LAST_POS
		|=> !byte_in.ready)
		else $error("input not stalled for compression");

endmodule
